// ===== design/a2u_pkg.sv =====
// Shared types, character codes and helpers for the ASCII to unsigned parser.
`default_nettype none
package a2u_pkg;

	localparam int CH_W   = 8;
	localparam int BASE_W = 6;

	localparam int DEF_VALUE_WIDTH = 32;
	localparam int DEF_COUNT_WIDTH = 8;

	localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
	localparam logic [BASE_W-1:0] BASE_AUTO  = BASE_W'(0);
	localparam logic [BASE_W-1:0] BASE_OCT   = BASE_W'(8);
	localparam logic [BASE_W-1:0] BASE_DEC   = BASE_W'(10);
	localparam logic [BASE_W-1:0] BASE_HEX   = BASE_W'(16);

	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
	localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;
	localparam logic [CH_W-1:0] CH_LO_X  = 8'h78;
	localparam logic [CH_W-1:0] CH_UP_X  = 8'h58;
	localparam logic [CH_W-1:0] NO_DIGIT = 8'hFF;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SIGNED,
		PH_ZERO,
		PH_HEXFIRST,
		PH_DIGITS
	} phase_t;

	// Digit value of a character, NO_DIGIT for anything that is not alphanumeric.
	function automatic logic [CH_W-1:0] digit_value(input logic [CH_W-1:0] c);
		logic [CH_W-1:0] r;
		r = NO_DIGIT;
		if (c >= CH_ZERO && c <= CH_NINE)
			r = c - CH_ZERO;
		else if (c >= CH_UP_A && c <= CH_UP_Z)
			r = c - (CH_UP_A - CH_W'(10));
		else if (c >= CH_LO_A && c <= CH_LO_Z)
			r = c - (CH_LO_A - CH_W'(10));
		return r;
	endfunction

	function automatic logic is_space(input logic [CH_W-1:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage
`default_nettype wire

// ===== design/ascii_to_unsigned_parser.sv =====
// ASCII to unsigned parser: one character per word in, one parsed number per string out.
//
// Input channel: ch with in_valid / in_stall, one character per accepted word.
// Leading whitespace, an optional sign and an optional 0x prefix are taken, then
// digits below the base. The first character that cannot continue the number
// ends the parse; it is not counted and yields one word on the output channel
// (value, overflowed, digits_seen, consumed_length) with out_valid / out_stall.
// Configuration: cfg_write with cfg_data sets the base (0 = auto); the base is
// sampled on each character while the parser sits idle.
// Throughput: one character per cycle while in_stall is low. Each character is
// resolved by the state update in the cycle it is accepted (one base-wide
// multiply-add and compare). The result word is registered in the output register,
// or in the skid register while the output register is stalled.
// Stall: an output register plus one skid register; in_stall rises only while
// the skid register holds a word, i.e. after a second result arrived behind a
// stalled one.
// Reset: parser goes idle with cleared state, base resets to 10, both result
// registers are empty.
`default_nettype none
module ascii_to_unsigned_parser #(
	parameter int VALUE_WIDTH = a2u_pkg::DEF_VALUE_WIDTH,
	parameter int COUNT_WIDTH = a2u_pkg::DEF_COUNT_WIDTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_write,
	input  wire logic [a2u_pkg::BASE_W-1:0] cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [a2u_pkg::CH_W-1:0]   ch,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [VALUE_WIDTH-1:0]          value,
	output logic                            overflowed,
	output logic                            digits_seen,
	output logic [COUNT_WIDTH-1:0]          consumed_length
);
	import a2u_pkg::*;

	localparam int PROD_W = VALUE_WIDTH + BASE_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	// configuration and parse state
	logic [BASE_W-1:0]      cfg_base_q;
	phase_t                 phase_q, phase_nxt;
	logic [VALUE_WIDTH-1:0] acc_q, acc_nxt;
	logic [BASE_W-1:0]      base_q, base_nxt;
	logic                   neg_q, neg_nxt;
	logic                   ovf_q, ovf_nxt;
	logic                   any_q, any_nxt;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_nxt, cnt_inc;

	// result registers
	logic                   out_vld_q, skid_vld_q;
	logic [VALUE_WIDTH-1:0] out_val_q, skid_val_q;
	logic                   out_ovf_q, skid_ovf_q;
	logic                   out_any_q, skid_any_q;
	logic [COUNT_WIDTH-1:0] out_len_q, skid_len_q;

	logic                   accept, fin, out_ready;
	logic                   dig_req, any_force;
	logic [BASE_W-1:0]      first_base, first_eff, dig_base, dig_eff;
	logic [CH_W-1:0]        dig_d;
	logic [PROD_W-1:0]      prod;
	logic                   prod_ovf;
	logic                   res_any;
	logic [VALUE_WIDTH-1:0] res_val;
	logic [COUNT_WIDTH-1:0] res_len;

	assign in_stall  = skid_vld_q;
	assign accept    = in_valid && !skid_vld_q;
	assign out_ready = !out_vld_q || !out_stall;

	assign cnt_inc = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + COUNT_WIDTH'(1);
	assign dig_d   = digit_value(ch);

	assign first_base = (phase_q == PH_IDLE) ? cfg_base_q : base_q;
	assign first_eff  = (first_base == BASE_AUTO) ? BASE_DEC : first_base;

	// base for a digit taken in this cycle; after a lone leading zero it is octal or hex
	assign dig_base = (phase_q == PH_IDLE || phase_q == PH_SIGNED) ? first_eff :
			(phase_q == PH_ZERO) ? ((base_q == BASE_HEX) ? BASE_HEX : BASE_OCT) : base_q;

	// digit step: multiply-add in a wider word, the top bits flag overflow
	assign dig_eff  = (dig_base == BASE_AUTO) ? BASE_DEC : dig_base;
	assign prod     = PROD_W'(acc_q) * PROD_W'(dig_eff) + PROD_W'(dig_d);
	assign prod_ovf = |prod[PROD_W-1:VALUE_WIDTH];

	always_comb begin
		phase_nxt = phase_q;
		acc_nxt   = acc_q;
		base_nxt  = base_q;
		neg_nxt   = neg_q;
		ovf_nxt   = ovf_q;
		any_nxt   = any_q;
		cnt_nxt   = cnt_q;
		dig_req   = 1'b0;
		any_force = 1'b0;
		fin       = 1'b0;

		unique case (phase_q)
			PH_IDLE, PH_SIGNED: begin
				base_nxt = first_base;
				if (phase_q == PH_IDLE && is_space(ch)) begin
					cnt_nxt = cnt_inc;
				end else if (phase_q == PH_IDLE && (ch == CH_MINUS || ch == CH_PLUS)) begin
					neg_nxt   = (ch == CH_MINUS);
					cnt_nxt   = cnt_inc;
					phase_nxt = PH_SIGNED;
				end else if ((first_base == BASE_AUTO || first_base == BASE_HEX) &&
						ch == CH_ZERO) begin
					cnt_nxt   = cnt_inc;
					phase_nxt = PH_ZERO;
				end else begin
					base_nxt  = first_eff;
					phase_nxt = PH_DIGITS;
					dig_req   = 1'b1;
				end
			end
			PH_ZERO: begin
				if (ch == CH_LO_X || ch == CH_UP_X) begin
					cnt_nxt   = cnt_inc;
					base_nxt  = BASE_HEX;
					phase_nxt = PH_HEXFIRST;
				end else begin
					// the leading zero counts as a digit; accumulator is still zero
					base_nxt  = (base_q == BASE_HEX) ? BASE_HEX : BASE_OCT;
					any_nxt   = 1'b1;
					any_force = 1'b1;
					phase_nxt = PH_DIGITS;
					dig_req   = 1'b1;
				end
			end
			PH_HEXFIRST, PH_DIGITS: begin
				phase_nxt = PH_DIGITS;
				dig_req   = 1'b1;
			end
			default: begin
				phase_nxt = PH_DIGITS;
				dig_req   = 1'b1;
			end
		endcase

		if (dig_req) begin
			if (dig_d >= CH_W'(dig_eff)) begin
				fin = 1'b1;
			end else begin
				if (ovf_q || prod_ovf)
					ovf_nxt = 1'b1;
				else
					acc_nxt = prod[VALUE_WIDTH-1:0];
				any_nxt = 1'b1;
				cnt_nxt = cnt_inc;
			end
		end

		// terminator: drop the parse state
		if (fin) begin
			phase_nxt = PH_IDLE;
			acc_nxt   = '0;
			base_nxt  = BASE_AUTO;
			neg_nxt   = 1'b0;
			ovf_nxt   = 1'b0;
			any_nxt   = 1'b0;
			cnt_nxt   = '0;
		end
	end

	assign res_any = any_q || any_force;
	assign res_val = ovf_q ? {VALUE_WIDTH{1'b1}} :
			neg_q ? {VALUE_WIDTH{1'b0}} - acc_q : acc_q;
	assign res_len = res_any ? cnt_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_base_q <= BASE_RESET;
		end else if (cfg_write) begin
			cfg_base_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			base_q  <= BASE_AUTO;
			neg_q   <= 1'b0;
			ovf_q   <= 1'b0;
			any_q   <= 1'b0;
			cnt_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			acc_q   <= acc_nxt;
			base_q  <= base_nxt;
			neg_q   <= neg_nxt;
			ovf_q   <= ovf_nxt;
			any_q   <= any_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_ready) begin
			out_vld_q  <= skid_vld_q || (accept && fin);
			skid_vld_q <= 1'b0;
		end else if (accept && fin) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready) begin
			if (skid_vld_q) begin
				out_val_q <= skid_val_q;
				out_ovf_q <= skid_ovf_q;
				out_any_q <= skid_any_q;
				out_len_q <= skid_len_q;
			end else begin
				out_val_q <= res_val;
				out_ovf_q <= ovf_q;
				out_any_q <= res_any;
				out_len_q <= res_len;
			end
		end else if (accept && fin) begin
			skid_val_q <= res_val;
			skid_ovf_q <= ovf_q;
			skid_any_q <= res_any;
			skid_len_q <= res_len;
		end
	end

	assign out_valid       = out_vld_q;
	assign value           = out_val_q;
	assign overflowed      = out_ovf_q;
	assign digits_seen     = out_any_q;
	assign consumed_length = out_len_q;

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid word held with empty output register");

	a_stalled_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_stall |=> out_vld_q)
		else $error("stalled result word lost");

	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && fin |=> phase_q == PH_IDLE && acc_q == '0 && cnt_q == '0 && !any_q)
		else $error("parse state not cleared after terminator");

	a_no_digit_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !out_any_q |-> out_val_q == '0 && out_len_q == '0 && !out_ovf_q)
		else $error("digitless result carries nonzero fields");

	a_count_only_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !fin |=> cnt_q >= $past(cnt_q))
		else $error("character count went backward mid-parse");
`endif

endmodule
`default_nettype wire
